>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// define NO_ASSERTIONS to compile them out
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

>>> rtl/core/scedd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scedd_pkg
// types, codes, weight tables and reset values of the curve dither
// ---------------------------------------------------------------------------
package scedd_pkg;

  // fixed field widths
  localparam int PIXEL_W     = 8;
  localparam int COORD_W     = 14;
  localparam int DIM_W       = 13;
  localparam int ADDR_W      = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // parameter defaults
  localparam int HISTORY_TAPS_DEF  = 16;
  localparam int MAX_IMAGE_DIM_DEF = 4096;
  localparam int ERROR_BITS_DEF    = 12;

  // weight tables, newest entry first
  localparam int ORIG_TAPS = 16;
  localparam int MOD_TAPS  = 8;
  localparam logic [4:0] ORIG_WEIGHTS [ORIG_TAPS] = '{
    5'd16, 5'd13, 5'd11, 5'd9, 5'd8, 5'd6, 5'd5, 5'd4,
    5'd4, 5'd3, 5'd3, 5'd2, 5'd2, 5'd1, 5'd1, 5'd1
  };
  localparam logic [15:0] MOD_WEIGHTS [MOD_TAPS] = '{
    16'd38019, 16'd15985, 16'd6721, 16'd2826, 16'd1188, 16'd500, 16'd210, 16'd88
  };

  // reset values of registers and turtle state
  localparam logic             RESET_MODE   = 1'b1;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd256;
  localparam logic [COORD_W-1:0] RESET_POS_X = 14'd0;
  localparam logic [COORD_W-1:0] RESET_POS_Y = 14'd0;
  localparam logic [1:0]       RESET_DIR_X  = 2'b01;
  localparam logic [1:0]       RESET_DIR_Y  = 2'b00;

  // item kinds
  typedef enum logic {
    REQ_SYMBOL = 1'b0,
    REQ_PIXEL  = 1'b1
  } req_t;

  // curve symbols
  typedef enum logic [1:0] {
    SYM_NOP        = 2'd0,
    SYM_FORWARD    = 2'd1,
    SYM_TURN_PLUS  = 2'd2,
    SYM_TURN_MINUS = 2'd3
  } sym_t;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGINAL_MODE = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_START_X       = 3'd3,
    REG_START_Y       = 3'd4,
    REG_START_DIR_X   = 3'd5,
    REG_START_DIR_Y   = 3'd6
  } cfg_reg_t;

  // configuration write
  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // step command to the turtle
  typedef struct packed {
    logic       fire;
    logic       is_symbol;
    logic [1:0] symbol;
  } turtle_cmd_t;

  // position report from the turtle
  typedef struct packed {
    logic              in_image;
    logic [ADDR_W-1:0] address;
  } pos_rpt_t;

endpackage

>>> rtl/core/scedd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scedd_in_if
// input channel: curve symbol or pixel items
// ---------------------------------------------------------------------------
interface scedd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [1:0]                    symbol;
  logic [scedd_pkg::PIXEL_W-1:0] pixel_value;

  modport source (output valid, req_type, symbol, pixel_value, input ready);
  modport sink   (input valid, req_type, symbol, pixel_value, output ready);
endinterface

>>> rtl/core/scedd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scedd_out_if
// result channel: position reports and dither decisions
// ---------------------------------------------------------------------------
interface scedd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic                         inside_res;
  logic [scedd_pkg::ADDR_W-1:0] pixel_address;
  logic                         dot_on;

  modport source (output valid, result_kind, inside_res, pixel_address, dot_on,
                  input ready);
  modport sink   (input valid, result_kind, inside_res, pixel_address, dot_on,
                  output ready);
endinterface

>>> rtl/core/scedd_turtle.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scedd_turtle
// curve walker: position, heading, image bounds and linear address
// ---------------------------------------------------------------------------
module scedd_turtle #(
  parameter int MAX_IMAGE_DIM = scedd_pkg::MAX_IMAGE_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  scedd_pkg::cfg_wr_t     cfg,
  input  scedd_pkg::turtle_cmd_t cmd,
  output scedd_pkg::pos_rpt_t    rpt
);

  localparam int CW   = scedd_pkg::COORD_W;
  localparam int DW   = scedd_pkg::DIM_W;
  localparam int AW   = scedd_pkg::ADDR_W;
  localparam int PW   = DW + CW;
  localparam logic [CW-1:0] DIM_MAX = CW'(MAX_IMAGE_DIM);

  logic [DW-1:0] image_width;
  logic [DW-1:0] image_height;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;
  logic [1:0]    dir_x;
  logic [1:0]    dir_y;

  logic [CW-1:0] pos_x_next;
  logic [CW-1:0] pos_y_next;
  logic [1:0]    dir_x_next;
  logic [1:0]    dir_y_next;
  logic [CW-1:0] width_clip;
  logic [CW-1:0] height_clip;
  logic          in_image;
  logic [PW-1:0] row_base;

  // heading and position after the step
  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    dir_x_next = dir_x;
    dir_y_next = dir_y;
    if (cmd.is_symbol) begin
      case (scedd_pkg::sym_t'(cmd.symbol))
        scedd_pkg::SYM_FORWARD: begin
          pos_x_next = pos_x + {{(CW-2){dir_x[1]}}, dir_x};
          pos_y_next = pos_y + {{(CW-2){dir_y[1]}}, dir_y};
        end
        scedd_pkg::SYM_TURN_PLUS: begin
          dir_x_next = dir_y;
          dir_y_next = 2'(-dir_x);
        end
        scedd_pkg::SYM_TURN_MINUS: begin
          dir_x_next = 2'(-dir_y);
          dir_y_next = dir_x;
        end
        default: begin
        end
      endcase
    end
  end

  // bounds clipped to the largest supported image
  always_comb begin
    width_clip  = ({1'b0, image_width} > DIM_MAX) ? DIM_MAX : {1'b0, image_width};
    height_clip = ({1'b0, image_height} > DIM_MAX) ? DIM_MAX : {1'b0, image_height};
  end

  // inside test and address of the position after the step
  always_comb begin
    in_image = !pos_x_next[CW-1] && !pos_y_next[CW-1] &&
               ({1'b0, pos_x_next[CW-2:0]} < width_clip) &&
               ({1'b0, pos_y_next[CW-2:0]} < height_clip);
    row_base = PW'(pos_y_next[CW-2:0]) * PW'(width_clip);
    rpt.in_image = in_image;
    rpt.address  = in_image ? AW'(row_base + PW'(pos_x_next[CW-2:0])) : '0;
  end

  // bounds registers and turtle state, loaded by register writes and stepped by symbol commands
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= scedd_pkg::RESET_WIDTH;
      image_height <= scedd_pkg::RESET_HEIGHT;
      pos_x        <= scedd_pkg::RESET_POS_X;
      pos_y        <= scedd_pkg::RESET_POS_Y;
      dir_x        <= scedd_pkg::RESET_DIR_X;
      dir_y        <= scedd_pkg::RESET_DIR_Y;
    end else if (cfg.we) begin
      case (scedd_pkg::cfg_reg_t'(cfg.index))
        scedd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        scedd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        scedd_pkg::REG_START_X:      pos_x        <= {1'b0, cfg.data};
        scedd_pkg::REG_START_Y:      pos_y        <= {1'b0, cfg.data};
        scedd_pkg::REG_START_DIR_X:  dir_x        <= cfg.data[1:0];
        scedd_pkg::REG_START_DIR_Y:  dir_y        <= cfg.data[1:0];
        default: begin
        end
      endcase
    end else if (cmd.fire && cmd.is_symbol) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      dir_x <= dir_x_next;
      dir_y <= dir_y_next;
    end
  end

endmodule

>>> rtl/core/scedd_dither.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scedd_dither
// error history shift line, weighted adder trees and threshold
// ---------------------------------------------------------------------------
module scedd_dither #(
  parameter int HISTORY_TAPS = scedd_pkg::HISTORY_TAPS_DEF,
  parameter int ERROR_BITS   = scedd_pkg::ERROR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scedd_pkg::cfg_wr_t            cfg,
  input  logic                          fire,
  input  logic [scedd_pkg::PIXEL_W-1:0] pixel_value,
  output logic                          dot
);

  localparam int EB = ERROR_BITS;
  localparam int OW = EB + 8;
  localparam int MW = EB + 18;
  localparam int RW = MW - 16;
  localparam int OT = scedd_pkg::ORIG_TAPS;
  localparam int MT = scedd_pkg::MOD_TAPS;
  localparam logic signed [OW-1:0] ORIG_THRESH = OW'(2048);
  localparam logic signed [MW-1:0] MOD_THRESH  = MW'(128 * 65536);
  localparam logic signed [MW-1:0] MOD_WHITE   = MW'(256 * 65536);
  localparam logic signed [MW-1:0] MOD_HALF    = MW'(32768);
  localparam logic signed [RW-1:0] ERR_MAX     = RW'((1 << (EB - 1)) - 1);
  localparam logic signed [RW-1:0] ERR_MIN     = -RW'(1 << (EB - 1));

  logic                 original_mode;
  logic signed [EB-1:0] hist [HISTORY_TAPS];

  logic signed [OW-1:0] prod_o [OT];
  logic signed [OW-1:0] o8 [8];
  logic signed [OW-1:0] o4 [4];
  logic signed [OW-1:0] o2 [2];
  logic signed [OW-1:0] val_o;
  logic                 dot_o;
  logic signed [9:0]    ne_o;

  logic signed [MW-1:0] prod_m [MT];
  logic signed [MW-1:0] m4 [4];
  logic signed [MW-1:0] m2 [2];
  logic signed [MW-1:0] val_m;
  logic                 dot_m;
  logic signed [MW-1:0] rem_m;
  logic signed [MW-1:0] rnd_m;
  logic signed [RW-1:0] ne_m;
  logic signed [EB-1:0] sat_m;
  logic signed [EB-1:0] new_err;

  // original mode products, taps past the history read as zero
  for (genvar i = 0; i < OT; i++) begin : g_orig
    if (i < HISTORY_TAPS) begin : g_tap
      assign prod_o[i] = OW'(hist[i]) * $signed(OW'(scedd_pkg::ORIG_WEIGHTS[i]));
    end else begin : g_pad
      assign prod_o[i] = '0;
    end
  end

  // modified mode products over the newest eight entries
  for (genvar i = 0; i < MT; i++) begin : g_mod
    assign prod_m[i] = MW'(hist[i]) * $signed(MW'(scedd_pkg::MOD_WEIGHTS[i]));
  end

  // original mode adder tree and threshold
  always_comb begin
    for (int j = 0; j < 8; j++) o8[j] = prod_o[2*j] + prod_o[2*j+1];
    for (int j = 0; j < 4; j++) o4[j] = o8[2*j] + o8[2*j+1];
    for (int j = 0; j < 2; j++) o2[j] = o4[2*j] + o4[2*j+1];
    val_o = o2[0] + o2[1] + $signed(OW'({pixel_value, 4'b0000}));
    dot_o = val_o > ORIG_THRESH;
    // error stays within -256..255, well inside the saturation range
    ne_o  = $signed({2'b00, pixel_value}) - (dot_o ? 10'sd256 : 10'sd0);
  end

  // modified mode adder tree, threshold, rounding and saturation
  always_comb begin
    for (int j = 0; j < 4; j++) m4[j] = prod_m[2*j] + prod_m[2*j+1];
    for (int j = 0; j < 2; j++) m2[j] = m4[2*j] + m4[2*j+1];
    val_m = m2[0] + m2[1] + $signed(MW'({pixel_value, 16'h0000}));
    dot_m = val_m > MOD_THRESH;
    rem_m = dot_m ? (val_m - MOD_WHITE) : val_m;
    rnd_m = rem_m + MOD_HALF;
    ne_m  = rnd_m[MW-1:16];
    if (ne_m > ERR_MAX) begin
      sat_m = EB'(ERR_MAX);
    end else if (ne_m < ERR_MIN) begin
      sat_m = EB'(ERR_MIN);
    end else begin
      sat_m = EB'(ne_m);
    end
  end

  // mode select
  always_comb begin
    dot     = original_mode ? dot_o : dot_m;
    new_err = original_mode ? EB'(ne_o) : sat_m;
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      original_mode <= scedd_pkg::RESET_MODE;
    end else if (cfg.we &&
                 scedd_pkg::cfg_reg_t'(cfg.index) == scedd_pkg::REG_ORIGINAL_MODE) begin
      original_mode <= cfg.data[0];
    end
  end

  // error history shift line, newest at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_TAPS; i++) hist[i] <= '0;
    end else if (fire) begin
      hist[0] <= new_err;
      for (int i = 1; i < HISTORY_TAPS; i++) hist[i] <= hist[i-1];
    end
  end

endmodule

>>> rtl/core/space_curve_error_diffusion_dither.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// space_curve_error_diffusion_dither
// binary error diffusion dither along a space-filling curve
// ---------------------------------------------------------------------------
// in_ch carries curve symbol items and pixel items; every item gives one
// result on out_ch: a position report for a symbol (inside flag and linear
// address after the step) or a dither decision for a pixel at the current
// position. Registers are written through cfg_we / cfg_index / cfg_data
// only while the block is idle; the user must see to it, as the block does
// not enforce it. Start writes load the turtle position at once. An
// accepted item is held in the input register and its result is registered
// in the result register. One item is taken every cycle while out_ch does
// not stall: the error of a pixel is fed back into the history in the same
// cycle that decides it, through the dither unit's weighted adder trees.
// Reset selects original mode, a 256 x 256 image, position (0,0) heading
// +x and a zero error history, all at once with no clearing pass.
// While out_ch stalls, the result is held and one more item can wait in the
// input register; after that in_ch.ready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module space_curve_error_diffusion_dither #(
  parameter int HISTORY_TAPS  = scedd_pkg::HISTORY_TAPS_DEF,
  parameter int MAX_IMAGE_DIM = scedd_pkg::MAX_IMAGE_DIM_DEF,
  parameter int ERROR_BITS    = scedd_pkg::ERROR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  scedd_in_if.sink                          in_ch,
  scedd_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [scedd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scedd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                          s1_valid;
  logic                          s1_req;
  logic [1:0]                    s1_sym;
  logic [scedd_pkg::PIXEL_W-1:0] s1_pix;

  logic                         res_valid;
  logic                         res_kind;
  logic                         res_inside;
  logic [scedd_pkg::ADDR_W-1:0] res_addr;
  logic                         res_dot;

  logic                   advance;
  logic                   in_take;
  logic                   is_pixel;
  logic                   dither_fire;
  logic                   dot;
  scedd_pkg::cfg_wr_t     cfg;
  scedd_pkg::turtle_cmd_t cmd;
  scedd_pkg::pos_rpt_t    rpt;

  // handshake control
  always_comb begin
    advance      = s1_valid && (!res_valid || out_ch.ready);
    in_ch.ready  = !s1_valid || advance;
    in_take      = in_ch.valid && in_ch.ready;
    is_pixel     = scedd_pkg::req_t'(s1_req) == scedd_pkg::REQ_PIXEL;
    dither_fire  = advance && is_pixel && rpt.in_image;
    cfg.we       = cfg_we;
    cfg.index    = cfg_index;
    cfg.data     = cfg_data;
    cmd.fire     = advance;
    cmd.is_symbol = !is_pixel;
    cmd.symbol   = s1_sym;
  end

  scedd_turtle #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_turtle (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .rpt (rpt)
  );

  scedd_dither #(
    .HISTORY_TAPS (HISTORY_TAPS),
    .ERROR_BITS   (ERROR_BITS)
  ) u_dither (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (dither_fire),
    .pixel_value (s1_pix),
    .dot         (dot)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req <= in_ch.req_type;
      s1_sym <= in_ch.symbol;
      s1_pix <= in_ch.pixel_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind   <= s1_req;
      res_inside <= rpt.in_image;
      res_addr   <= rpt.address;
      res_dot    <= is_pixel && rpt.in_image && dot;
    end
  end

  // result channel
  always_comb begin
    out_ch.valid         = res_valid;
    out_ch.result_kind   = res_kind;
    out_ch.inside_res    = res_inside;
    out_ch.pixel_address = res_addr;
    out_ch.dot_on        = res_dot;
  end

  // checks
  `ASSERT_IMPLY(a_report_no_dot, clk, rst, out_ch.valid && !out_ch.result_kind, !out_ch.dot_on)
  `ASSERT_IMPLY(a_outside_blank, clk, rst, out_ch.valid && !out_ch.inside_res, out_ch.pixel_address == '0 && !out_ch.dot_on)
  `ASSERT_IMPLY(a_full_blocks, clk, rst, s1_valid && out_ch.valid && !out_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_take_fills, clk, rst, in_ch.valid && in_ch.ready, s1_valid)

endmodule

>>> tb/tb_space_curve_error_diffusion_dither.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_space_curve_error_diffusion_dither
// self-checking bench for the curve walking error diffusion dither
// ---------------------------------------------------------------------------
// A directed table covers the start-up state, field extremes, every symbol,
// outside-image pixels, heading -2, clipped and zero dimensions, a mode
// change with a live history and a write to an unused index. Random phases
// follow, each with its own register setting. Most items in those phases
// form a steered walk (turn at the image edge, forward, pixel), and the rest
// are noise. Every accepted item is run through an in-bench turtle and
// dither model, and each result is checked field by field, in order.
// ---------------------------------------------------------------------------
module tb_space_curve_error_diffusion_dither;
  import scedd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DIM_CAP = MAX_IMAGE_DIM_DEF;
  localparam int ERR_MAX = 2047;
  localparam int ERR_MIN = -2048;
  localparam int PLAN_LEN = 36;
  localparam int PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;

  // tap weights, newest error first
  localparam int CLASSIC_W [16] = '{16, 13, 11, 9, 8, 6, 5, 4, 4, 3, 3, 2, 2, 1, 1, 1};
  localparam longint DECAY_W [8] = '{38019, 15985, 6721, 2826, 1188, 500, 210, 88};

  typedef struct packed {
    logic              kind;
    logic              in_img;
    logic [ADDR_W-1:0] addr;
    logic              dot;
  } result_t;

  typedef struct packed {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    req_t                   req;
    sym_t                   sym;
    logic [PIXEL_W-1:0]     pix;
    bit                     typed;
    result_t                res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scedd_in_if in_ch ();
  scedd_out_if out_ch ();

  space_curve_error_diffusion_dither uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state: registers, turtle and error history
  logic                  orig_mode;
  logic [DIM_W-1:0]      img_w, img_h;
  logic [COORD_W-1:0]    cur_x, cur_y;
  logic signed [1:0]     head_x, head_y;
  logic signed [11:0]    err_hist [16];

  result_t   pending [$];
  plan_row_t plan [PLAN_LEN];
  int        mism = 0;
  int        src_idle_pct = 0;
  int        stall_pct = 0;
  bit        stepped = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  function automatic int clipped(logic [DIM_W-1:0] d);
    return (int'(d) > DIM_CAP) ? DIM_CAP : int'(d);
  endfunction

  function automatic bit in_bounds(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    return !x[COORD_W-1] && !y[COORD_W-1] &&
           int'(x) < clipped(img_w) && int'(y) < clipped(img_h);
  endfunction

  function automatic logic [COORD_W-1:0] stretch(logic [1:0] d);
    return {{(COORD_W-2){d[1]}}, d};
  endfunction

  task automatic reset_model();
    orig_mode = RESET_MODE;
    img_w     = RESET_WIDTH;
    img_h     = RESET_HEIGHT;
    cur_x     = RESET_POS_X;
    cur_y     = RESET_POS_Y;
    head_x    = RESET_DIR_X;
    head_y    = RESET_DIR_Y;
    for (int i = 0; i < 16; i++) err_hist[i] = '0;
  endtask

  // advance the turtle or dither one pixel, return the result it gives
  function automatic result_t walk_and_dither(req_t rq, sym_t sy, logic [PIXEL_W-1:0] px);
    result_t r;
    logic signed [1:0] t;
    longint acc, pv, v, ne;
    bit ins;
    r = '0;
    r.kind = rq;
    pv = longint'(px);
    if (rq == REQ_SYMBOL) begin
      case (sy)
        SYM_FORWARD: begin
          cur_x = cur_x + stretch(head_x);
          cur_y = cur_y + stretch(head_y);
        end
        SYM_TURN_PLUS: begin
          t = head_y;
          head_y = -head_x;
          head_x = t;
        end
        SYM_TURN_MINUS: begin
          t = -head_y;
          head_y = head_x;
          head_x = t;
        end
        default: ;
      endcase
      ins = in_bounds(cur_x, cur_y);
    end else begin
      ins = in_bounds(cur_x, cur_y);
      if (ins) begin
        acc = 0;
        if (orig_mode) begin
          for (int i = 0; i < 16; i++) acc += longint'(err_hist[i]) * CLASSIC_W[i];
          if (16 * pv + acc > 2048) begin
            r.dot = 1'b1;
            ne = pv - 256;
          end else begin
            ne = pv;
          end
        end else begin
          for (int i = 0; i < 8; i++) acc += longint'(err_hist[i]) * DECAY_W[i];
          v = acc + pv * 65536;
          if (v > 128 * 65536) begin
            r.dot = 1'b1;
            v -= 256 * 65536;
          end
          // round to nearest, ties up
          ne = (v + 32768) >>> 16;
        end
        if (ne > ERR_MAX) ne = ERR_MAX;
        if (ne < ERR_MIN) ne = ERR_MIN;
        for (int i = 15; i > 0; i--) err_hist[i] = err_hist[i-1];
        err_hist[0] = ne[11:0];
      end
    end
    r.in_img = ins;
    r.addr = ins ? ADDR_W'(int'(cur_y) * clipped(img_w) + int'(cur_x)) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // register write: held one edge, cfg_we is lowered by the next driver
  task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ORIGINAL_MODE: orig_mode = val[0];
      REG_IMAGE_WIDTH:   img_w = val;
      REG_IMAGE_HEIGHT:  img_h = val;
      REG_START_X:       cur_x = {1'b0, val};
      REG_START_Y:       cur_y = {1'b0, val};
      REG_START_DIR_X:   head_x = val[1:0];
      REG_START_DIR_Y:   head_y = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // offer one item until accepted, then record what it should give
  task automatic send_item(input req_t rq, input sym_t sy, input logic [PIXEL_W-1:0] px,
                           input bit typed, input result_t typed_res, output bit moved);
    bit took;
    result_t r;
    cfg_we <= 1'b0;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq;
    in_ch.symbol      <= sy;
    in_ch.pixel_value <= px;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    r = walk_and_dither(rq, sy, px);
    pending.push_back(typed ? typed_res : r);
    moved = !((rq == REQ_SYMBOL && sy == SYM_NOP) || (rq == REQ_PIXEL && !r.in_img));
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return 13'd1;
      3:       return 13'd4096;
      4, 5:    return DIM_W'($urandom_range(4097, 8191));
      6:       return DIM_W'($urandom_range(17, 4096));
      default: return DIM_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_start(logic [DIM_W-1:0] d);
    if (d == 0 || $urandom_range(0, 9) == 0) return DIM_W'($urandom_range(0, 8191));
    return DIM_W'($urandom_range(0, clipped(d) - 1));
  endfunction

  task automatic choose_setting(int ph);
    logic m;
    logic [DIM_W-1:0] w, h, sx, sy;
    logic [1:0] dx, dy;
    case (ph)
      0: begin
        // mode, bounds and start position at their top, start walks off into the wrap
        m = 1'b1; w = 13'h1fff; h = 13'h1fff; sx = 13'h1fff; sy = 13'h1fff;
        dx = 2'b01; dy = 2'b01;
      end
      1: begin
        // one-pixel image, heading -2 in y
        m = 1'b0; w = 13'd1; h = 13'd1; sx = '0; sy = '0;
        dx = 2'b00; dy = 2'b10;
      end
      default: begin
        m = 1'($urandom_range(0, 1));
        w = pick_dim();
        h = pick_dim();
        sx = pick_start(w);
        sy = pick_start(h);
        dx = 2'($urandom_range(0, 3));
        dy = 2'($urandom_range(0, 3));
        if (dx == 2'b00 && dy == 2'b00 && $urandom_range(0, 7) != 0) dx = 2'b01;
      end
    endcase
    set_register(REG_ORIGINAL_MODE, {12'd0, m});
    set_register(REG_IMAGE_WIDTH, w);
    set_register(REG_IMAGE_HEIGHT, h);
    set_register(REG_START_X, sx);
    set_register(REG_START_Y, sy);
    set_register(REG_START_DIR_X, {11'd0, dx});
    set_register(REG_START_DIR_Y, {11'd0, dy});
    if ($urandom_range(0, 3) == 0)
      set_register(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
  endtask

  // steered walk: turn at the edge, step, dither the new pixel; some noise
  task automatic next_random_item(output req_t rq, output sym_t sy,
                                  output logic [PIXEL_W-1:0] px);
    int r;
    r = $urandom_range(0, 99);
    sy = sym_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       px = 8'd0;
      1:       px = 8'd255;
      default: px = PIXEL_W'($urandom_range(0, 255));
    endcase
    if (r < 8) begin
      rq = req_t'($urandom_range(0, 1));
    end else if (stepped && in_bounds(cur_x, cur_y)) begin
      rq = REQ_PIXEL;
    end else begin
      rq = REQ_SYMBOL;
      if (!in_bounds(cur_x + stretch(head_x), cur_y + stretch(head_y)) && r < 80)
        sy = (r % 2 == 0) ? SYM_TURN_PLUS : SYM_TURN_MINUS;
      else if (r < 20)
        sy = (r % 2 == 0) ? SYM_TURN_PLUS : SYM_TURN_MINUS;
      else
        sy = SYM_FORWARD;
    end
    stepped = (rq == REQ_SYMBOL && sy == SYM_FORWARD);
  endtask

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t item_row(req_t rq, sym_t sy, logic [PIXEL_W-1:0] px);
    plan_row_t p;
    p = '0;
    p.req = rq;
    p.sym = sy;
    p.pix = px;
    return p;
  endfunction

  function automatic plan_row_t seen_row(req_t rq, sym_t sy, logic [PIXEL_W-1:0] px,
                                         logic ins, logic [ADDR_W-1:0] a, logic d);
    plan_row_t p;
    p = item_row(rq, sy, px);
    p.typed = 1'b1;
    p.res = '{kind: rq, in_img: ins, addr: a, dot: d};
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : result_check
    result_t got, want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.result_kind, out_ch.inside_res, out_ch.pixel_address, out_ch.dot_on};
      if (pending.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected result: kind=%0d in=%0d addr=%0d dot=%0d",
                   got.kind, got.in_img, got.addr, got.dot);
      end else begin
        want = pending.pop_front();
        if (got.kind !== want.kind || got.in_img !== want.in_img ||
            got.addr !== want.addr || got.dot !== want.dot) begin
          mism++;
          if (mism <= 10)
            $display({"mismatch at %0t: exp kind=%0d in=%0d addr=%0d dot=%0d,",
                      " got kind=%0d in=%0d addr=%0d dot=%0d"},
                     $realtime, want.kind, want.in_img, want.addr, want.dot,
                     got.kind, got.in_img, got.addr, got.dot);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) out_ch.ready <= 1'b0;
      else out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    req_t rq;
    sym_t sy;
    logic [PIXEL_W-1:0] px;
    bit moved, was_item;
    int counted;

    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_SYMBOL;
    in_ch.symbol      <= SYM_NOP;
    in_ch.pixel_value <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;

    plan = '{
      // reset state: origin heading +x, classic weights, 256 x 256
      seen_row(REQ_SYMBOL, SYM_NOP, 8'ha5, 1'b1, 24'd0, 1'b0),
      seen_row(REQ_PIXEL, SYM_FORWARD, 8'd255, 1'b1, 24'd0, 1'b1),
      // repeated pixel without a step
      seen_row(REQ_PIXEL, SYM_TURN_MINUS, 8'd0, 1'b1, 24'd0, 1'b0),
      seen_row(REQ_SYMBOL, SYM_FORWARD, 8'd255, 1'b1, 24'd1, 1'b0),
      seen_row(REQ_SYMBOL, SYM_TURN_PLUS, 8'd0, 1'b1, 24'd1, 1'b0),
      // step to a negative row, pixel there is outside
      seen_row(REQ_SYMBOL, SYM_FORWARD, 8'd0, 1'b0, 24'd0, 1'b0),
      seen_row(REQ_PIXEL, SYM_NOP, 8'd128, 1'b0, 24'd0, 1'b0),
      seen_row(REQ_SYMBOL, SYM_TURN_MINUS, 8'd0, 1'b0, 24'd0, 1'b0),
      seen_row(REQ_SYMBOL, SYM_TURN_MINUS, 8'd0, 1'b0, 24'd0, 1'b0),
      seen_row(REQ_SYMBOL, SYM_FORWARD, 8'd0, 1'b1, 24'd1, 1'b0),
      seen_row(REQ_SYMBOL, SYM_FORWARD, 8'd0, 1'b1, 24'd257, 1'b0),
      item_row(REQ_PIXEL, SYM_TURN_PLUS, 8'd128),
      item_row(REQ_PIXEL, SYM_NOP, 8'd255),
      // switch to normalized weights with the history kept
      cfg_row(REG_ORIGINAL_MODE, 13'd0),
      item_row(REQ_PIXEL, SYM_NOP, 8'd200),
      item_row(REQ_PIXEL, SYM_NOP, 8'd60),
      // heading -2, negation keeps it at -2
      cfg_row(REG_START_X, 13'd10),
      cfg_row(REG_START_Y, 13'd10),
      cfg_row(REG_START_DIR_X, 13'd2),
      cfg_row(REG_START_DIR_Y, 13'd0),
      item_row(REQ_SYMBOL, SYM_FORWARD, 8'd0),
      item_row(REQ_SYMBOL, SYM_TURN_PLUS, 8'd0),
      item_row(REQ_SYMBOL, SYM_FORWARD, 8'd0),
      item_row(REQ_SYMBOL, SYM_TURN_PLUS, 8'd0),
      item_row(REQ_SYMBOL, SYM_TURN_MINUS, 8'd0),
      // oversized width, zero height: nothing is inside
      cfg_row(REG_IMAGE_WIDTH, 13'h1fff),
      cfg_row(REG_IMAGE_HEIGHT, 13'd0),
      seen_row(REQ_SYMBOL, SYM_NOP, 8'd0, 1'b0, 24'd0, 1'b0),
      seen_row(REQ_PIXEL, SYM_NOP, 8'd255, 1'b0, 24'd0, 1'b0),
      // last pixel of a clipped 4096 x 4096 image
      cfg_row(REG_IMAGE_HEIGHT, 13'd4096),
      cfg_row(REG_START_X, 13'd4095),
      cfg_row(REG_START_Y, 13'd4095),
      seen_row(REQ_SYMBOL, SYM_NOP, 8'd0, 1'b1, 24'hffffff, 1'b0),
      item_row(REQ_PIXEL, SYM_NOP, 8'd255),
      // unused index changes nothing
      cfg_row(REG_UNUSED, 13'h1fff),
      item_row(REQ_SYMBOL, SYM_NOP, 8'd0)
    };

    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part
    was_item = 1'b0;
    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].is_cfg) begin
        if (was_item) settle();
        set_register(plan[k].reg_idx, plan[k].reg_val);
        was_item = 1'b0;
      end else begin
        send_item(plan[k].req, plan[k].sym, plan[k].pix, plan[k].typed, plan[k].res, moved);
        was_item = 1'b1;
      end
    end

    // random phases, one register setting and idle pattern each
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin src_idle_pct = 0;  stall_pct = 0;  end
        1: begin src_idle_pct = 49; stall_pct = 0;  end
        2: begin src_idle_pct = 0;  stall_pct = 49; end
        default: begin src_idle_pct = 28; stall_pct = 28; end
      endcase
      choose_setting(ph);
      stepped = 1'b0;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        next_random_item(rq, sy, px);
        send_item(rq, sy, px, 1'b0, '0, moved);
        if (moved) counted++;
      end
    end

    settle();
    repeat (5) @(posedge clk);
    if (mism == 0 && pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/scedd_pkg.sv
rtl/core/scedd_in_if.sv
rtl/core/scedd_out_if.sv
rtl/core/scedd_turtle.sv
rtl/core/scedd_dither.sv
rtl/core/space_curve_error_diffusion_dither.sv
tb/tb_space_curve_error_diffusion_dither.sv
